// ===== sv/dfir_pkg.sv =====
// ----------------------------------------------------------------------------
// dfir_pkg
// Shared types, constants and the coefficient table of the decimating
// symmetric FIR filter.
// ----------------------------------------------------------------------------
package dfir_pkg;

	localparam int TAP_COUNT_DEF  = 96;
	localparam int DECIMATION_DEF = 4;
	localparam int SAMPLE_W       = 16;
	localparam int COEF_W         = 12;
	localparam int OUT_SHIFT      = 13;
	localparam int SAT_HI         = 32767;
	localparam int SAT_LO         = -32768;
	localparam int SAT_LO_OUT     = -32767;
	localparam int TABLE_LEN      = 48;

	localparam logic signed [COEF_W-1:0] COEF_TABLE [TABLE_LEN] = '{
		-12'sd2,   -12'sd6,   -12'sd12,  -12'sd19,  -12'sd23,  -12'sd22,
		-12'sd14,  -12'sd1,    12'sd14,   12'sd25,   12'sd26,   12'sd16,
		-12'sd1,   -12'sd20,  -12'sd31,  -12'sd29,  -12'sd13,   12'sd11,
		 12'sd31,   12'sd39,   12'sd28,   12'sd2,   -12'sd28,  -12'sd46,
		-12'sd44,  -12'sd19,   12'sd18,   12'sd51,   12'sd61,   12'sd41,
		-12'sd3,   -12'sd51,  -12'sd80,  -12'sd71,  -12'sd23,   12'sd45,
		 12'sd102,  12'sd115,  12'sd68,  -12'sd28,  -12'sd135, -12'sd199,
		-12'sd170, -12'sd25,   12'sd219,  12'sd508,  12'sd765,  12'sd915
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN
	} dfir_state_t;

	typedef struct packed {
		logic wr_en;
		logic acc_clr;
		logic rd_en;
		logic out_load;
	} dfir_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_blocked;
	} dfir_status_t;

	// The table is aligned on its centre coefficient; taps outside it are zero.
	function automatic logic signed [COEF_W-1:0] coef_at(input int idx, input int half);
		int k;
		k = idx + TABLE_LEN - half;
		if (k < 0 || k >= TABLE_LEN) begin
			return '0;
		end
		return COEF_TABLE[k];
	endfunction

endpackage

// ===== sv/dfir_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfir_ctrl
// Controller: takes items, tracks the decimation phase and sequences the
// coefficient pairs through the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module dfir_ctrl #(
	parameter int TAP_COUNT  = dfir_pkg::TAP_COUNT_DEF,
	parameter int DECIMATION = dfir_pkg::DECIMATION_DEF,
	localparam int HALF      = TAP_COUNT / 2,
	localparam int IW        = $clog2(HALF),
	localparam int PW        = $clog2(DECIMATION)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output dfir_pkg::dfir_cmd_t  cmd,
	output logic [IW-1:0]        tap_idx,
	input  dfir_pkg::dfir_status_t status
);

	localparam logic [IW-1:0] LAST_IDX  = IW'(HALF - 1);
	localparam logic [PW-1:0] LAST_PHASE = PW'(DECIMATION - 1);

	dfir_pkg::dfir_state_t state_q, state_d;
	logic [IW-1:0] tap_idx_q, tap_idx_d;
	logic [PW-1:0] phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dfir_pkg::ST_IDLE;
			tap_idx_q <= '0;
			phase_q   <= '0;
		end else begin
			state_q   <= state_d;
			tap_idx_q <= tap_idx_d;
			phase_q   <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		tap_idx_d = tap_idx_q;
		phase_d   = phase_q;
		cmd       = '0;
		in_stall  = 1'b1;
		case (state_q)
			dfir_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.wr_en = 1'b1;
					phase_d   = (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;
					if (phase_q == '0) begin
						cmd.acc_clr = 1'b1;
						tap_idx_d   = '0;
						state_d     = dfir_pkg::ST_READ;
					end
				end
			end
			dfir_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				if (tap_idx_q == LAST_IDX) begin
					state_d = dfir_pkg::ST_DRAIN;
				end else begin
					tap_idx_d = tap_idx_q + 1'b1;
				end
			end
			dfir_pkg::ST_DRAIN: begin
				if (!status.pipe_busy && !status.out_blocked) begin
					cmd.out_load = 1'b1;
					state_d      = dfir_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dfir_pkg::ST_IDLE;
			end
		endcase
	end

	assign tap_idx = tap_idx_q;

endmodule

// ===== sv/dfir_dp.sv =====
// ----------------------------------------------------------------------------
// dfir_dp
// Datapath: channel select, circular sample history memory, symmetric pair
// adder, multiplier, accumulator, arithmetic shift, clamp and output register.
// ----------------------------------------------------------------------------
module dfir_dp #(
	parameter int TAP_COUNT = dfir_pkg::TAP_COUNT_DEF,
	localparam int HALF     = TAP_COUNT / 2,
	localparam int IW       = $clog2(HALF),
	localparam int SW       = dfir_pkg::SAMPLE_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	input  logic signed [SW-1:0]   right_sample,
	input  logic signed [SW-1:0]   left_sample,
	input  dfir_pkg::dfir_cmd_t    cmd,
	input  logic [IW-1:0]          tap_idx,
	output dfir_pkg::dfir_status_t status,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic signed [SW-1:0]   low_rate_sample
);

	localparam int AW     = $clog2(TAP_COUNT);
	localparam int DEPTH  = 1 << AW;
	localparam int CW     = dfir_pkg::COEF_W;
	localparam int PAIR_W = SW + 1;
	localparam int PROD_W = PAIR_W + CW;
	localparam int ACC_W  = PROD_W + IW + 1;
	localparam int YW     = ACC_W - dfir_pkg::OUT_SHIFT;
	localparam logic [AW-1:0] LAST_TAP = AW'(TAP_COUNT - 1);
	localparam logic signed [YW-1:0] Y_HI = YW'(dfir_pkg::SAT_HI);
	localparam logic signed [YW-1:0] Y_LO = YW'(dfir_pkg::SAT_LO);
	localparam logic signed [SW-1:0] OUT_HI = SW'(dfir_pkg::SAT_HI);
	localparam logic signed [SW-1:0] OUT_LO = SW'(dfir_pkg::SAT_LO_OUT);

	logic                  take_left_q;
	logic [AW-1:0]         wptr_q;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         addr_a;
	logic [AW-1:0]         addr_b;
	logic [DEPTH-1:0]      hist_vld_q;
	logic signed [SW-1:0]  hist_mem [DEPTH];
	logic signed [SW-1:0]  cur_sample;

	logic                  v_s1, v_s2, v_s3;
	logic signed [SW-1:0]  mem_a_s1, mem_b_s1;
	logic                  vld_a_s1, vld_b_s1;
	logic signed [CW-1:0]  coef_s1, coef_s2;
	logic signed [PAIR_W-1:0] pair_s2;
	logic signed [PROD_W-1:0] prod_s3;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PAIR_W-1:0] pair_sum;
	logic signed [YW-1:0]     y_shift;
	logic signed [SW-1:0]     y_clamp;

	logic                  out_valid_q;
	logic signed [SW-1:0]  out_sample_q;

	assign cur_sample = take_left_q ? left_sample : right_sample;
	assign wr_addr    = wptr_q + 1'b1;
	assign addr_a     = wptr_q - AW'(tap_idx);
	assign addr_b     = wptr_q - (LAST_TAP - AW'(tap_idx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_left_q <= 1'b1;
			wptr_q      <= '0;
			hist_vld_q  <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				take_left_q <= cfg_wdata;
			end
			if (cmd.wr_en) begin
				wptr_q              <= wr_addr;
				hist_vld_q[wr_addr] <= 1'b1;
			end
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			hist_mem[wr_addr] <= cur_sample;
		end
		mem_a_s1 <= hist_mem[addr_a];
		mem_b_s1 <= hist_mem[addr_b];
	end

	always_ff @(posedge clk) begin
		vld_a_s1 <= hist_vld_q[addr_a];
		vld_b_s1 <= hist_vld_q[addr_b];
		coef_s1  <= dfir_pkg::coef_at(int'(tap_idx), HALF);
		pair_s2  <= pair_sum;
		coef_s2  <= coef_s1;
		prod_s3  <= pair_s2 * coef_s2;
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(prod_s3);
		end
		if (cmd.out_load) begin
			out_sample_q <= y_clamp;
		end
	end

	always_comb begin
		pair_sum = (vld_a_s1 ? PAIR_W'(mem_a_s1) : '0) + (vld_b_s1 ? PAIR_W'(mem_b_s1) : '0);
	end

	always_comb begin
		y_shift = YW'(acc_q >>> dfir_pkg::OUT_SHIFT);
		if (y_shift > Y_HI) begin
			y_clamp = OUT_HI;
		end else if (y_shift < Y_LO) begin
			y_clamp = OUT_LO;
		end else begin
			y_clamp = y_shift[SW-1:0];
		end
	end

	assign status.pipe_busy   = v_s1 | v_s2 | v_s3;
	assign status.out_blocked = out_valid_q & out_stall;
	assign out_valid          = out_valid_q;
	assign low_rate_sample    = out_sample_q;

endmodule

// ===== sv/decimate_by_four_symmetric_fir_top.sv =====
// ----------------------------------------------------------------------------
// decimate_by_four_symmetric_fir_top
// Stereo in, mono out low-pass FIR that keeps one output for every four
// input items.
// ----------------------------------------------------------------------------
// Each input item is a stereo pair; cfg_we with cfg_wdata selects the left
// (1, the reset value) or right (0) channel; the user is to write it only
// while idle, which the block does not enforce. Both channels use valid and
// stall; an item moves when valid is high and stall is low.
// The first item after reset and every fourth one after it produce one
// output item; the others only enter the history.
// An output item occupies the block while it is accepted, while its coefficient
// pairs pass one per cycle through the single multiply-accumulate unit, and
// while that unit's pipeline drains and the result is clamped. The output
// becomes valid when the controller leaves ST_DRAIN and loads the clamped
// result into the output register. In ST_READ and ST_DRAIN the input is
// stalled, so no new item is taken until the current output is loaded.
// Reset clears the history, the decimation phase and the output valid flag.
// A result that waits under stall stays in the output register; the block
// keeps taking items and only holds before loading the next result.
// ----------------------------------------------------------------------------
module decimate_by_four_symmetric_fir_top #(
	parameter int TAP_COUNT  = dfir_pkg::TAP_COUNT_DEF,
	parameter int DECIMATION = dfir_pkg::DECIMATION_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic                               cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [dfir_pkg::SAMPLE_W-1:0] right_sample,
	input  logic signed [dfir_pkg::SAMPLE_W-1:0] left_sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dfir_pkg::SAMPLE_W-1:0] low_rate_sample
);

	localparam int IW = $clog2(TAP_COUNT / 2);

	dfir_pkg::dfir_cmd_t    cmd;
	dfir_pkg::dfir_status_t status;
	logic [IW-1:0]          tap_idx;

	dfir_ctrl #(
		.TAP_COUNT  (TAP_COUNT),
		.DECIMATION (DECIMATION)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.tap_idx  (tap_idx),
		.status   (status)
	);

	dfir_dp #(
		.TAP_COUNT (TAP_COUNT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.right_sample    (right_sample),
		.left_sample     (left_sample),
		.cmd             (cmd),
		.tap_idx         (tap_idx),
		.status          (status),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.low_rate_sample (low_rate_sample)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the decimating stereo-to-mono symmetric FIR filter.
// ----------------------------------------------------------------------------
// A short table of directed stereo pairs comes first. After it, random
// segments follow: ordinary samples, full-scale bursts whose signs follow the
// coefficients so that the output clamps, and channel changes made while the
// block is idle. A predictor keeps its own copy of the sample history and of
// the decimation phase, and each output item is compared with the oldest
// expected value. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TAPS      = dfir_pkg::TAP_COUNT_DEF;
	localparam int HIST_LEN  = TAPS - 1;
	localparam int PAIRS     = TAPS / 2;
	localparam int DECIM     = dfir_pkg::DECIMATION_DEF;
	localparam int SETTLE    = TAPS / 2 + 12;
	localparam int STALL_MAX = 5000;
	localparam int RAND_ITEMS = 850;

	typedef logic signed [dfir_pkg::SAMPLE_W-1:0] sample_t;

	typedef struct {
		bit      take_left;
		sample_t right;
		sample_t left;
		bit      typed;
		sample_t typed_val;
	} stim_row_t;

	logic    clk;
	logic    arst_n;
	logic    cfg_we;
	logic    cfg_wdata;
	logic    in_valid;
	logic    in_stall;
	sample_t right_sample;
	sample_t left_sample;
	logic    out_valid;
	logic    out_stall;
	sample_t low_rate_sample;

	sample_t hist_mirror [HIST_LEN];
	int      phase_mirror;
	bit      chan_left;
	sample_t pending_out [$];
	int      err_count;
	int      idle_cycles;
	bit      quiet;
	sample_t want;

	decimate_by_four_symmetric_fir_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.right_sample   (right_sample),
		.left_sample    (left_sample),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.low_rate_sample(low_rate_sample)
	);

	always #1 clk = ~clk;

	task automatic fir_advance(input sample_t cur, output bit emits, output sample_t y);
		longint acc;
		longint pair;
		longint q;
		emits = 0;
		y = '0;
		if (phase_mirror == 0) begin
			acc = 0;
			for (int i = 0; i < PAIRS; i++) begin
				pair = longint'(i == 0 ? cur : hist_mirror[i-1]) +
					longint'(hist_mirror[HIST_LEN-1-i]);
				acc += longint'(dfir_pkg::COEF_TABLE[i + dfir_pkg::TABLE_LEN - PAIRS]) *
					pair;
			end
			q = acc >>> dfir_pkg::OUT_SHIFT;
			if (q > dfir_pkg::SAT_HI) begin
				q = dfir_pkg::SAT_HI;
			end
			if (q < dfir_pkg::SAT_LO) begin
				q = dfir_pkg::SAT_LO_OUT;
			end
			y = sample_t'(q);
			emits = 1;
		end
		for (int k = HIST_LEN - 1; k > 0; k--) begin
			hist_mirror[k] = hist_mirror[k-1];
		end
		hist_mirror[0] = cur;
		phase_mirror = (phase_mirror + 1) % DECIM;
	endtask

	task automatic send_pair(input sample_t r, input sample_t l, input bit typed,
			input sample_t typed_val);
		bit      emits;
		sample_t y;
		if (!quiet && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		right_sample <= r;
		left_sample  <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		fir_advance(chan_left ? l : r, emits, y);
		if (emits) begin
			pending_out.push_back(typed ? typed_val : y);
		end
	endtask

	task automatic set_channel(input bit v);
		in_valid <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		chan_left = v;
	endtask

	function automatic sample_t rand_sample();
		int sel;
		sel = $urandom_range(99);
		if (sel < 50) begin
			return sample_t'($urandom);
		end
		if (sel < 65) begin
			case ($urandom_range(3))
				0: return sample_t'(dfir_pkg::SAT_HI);
				1: return sample_t'(dfir_pkg::SAT_LO);
				2: return '0;
				default: return '1;
			endcase
		end
		return sample_t'($urandom_range(1024) - 512);
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_out.size() == 0) begin
				$error("low_rate_sample: unexpected item, actual %0d", low_rate_sample);
				err_count++;
			end else begin
				want = pending_out.pop_front();
				if (low_rate_sample !== want) begin
					$error("low_rate_sample: expected %0d, actual %0d", want,
						low_rate_sample);
					err_count++;
				end
			end
		end
		out_stall <= (!quiet && $urandom_range(99) < 27);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_MAX) begin
			$display("FAIL decimate_by_four_symmetric_fir_top");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		stim_row_t dir_rows [$];
		stim_row_t row;
		int        fed;
		int        sel;
		int        seg;
		int        lag;
		int        cidx;
		bit        pos;
		sample_t   s;

		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b1;
		in_valid     = 1'b0;
		right_sample = '0;
		left_sample  = '0;
		out_stall    = 1'b0;
		quiet        = 1'b0;
		err_count    = 0;
		idle_cycles  = 0;
		phase_mirror = 0;
		chan_left    = 1'b1;
		for (int k = 0; k < HIST_LEN; k++) begin
			hist_mirror[k] = '0;
		end

		// With an empty history only the newest sample meets the first coefficient.
		dir_rows.push_back(stim_row_t'{1'b1, -16'sd32768, 16'sd32767, 1'b1, -16'sd8});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sd32767, -16'sd32768, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sd0, -16'sd1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, -16'sd1, 16'sd0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sh5555, 16'shAAAA, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'shAAAA, 16'sh5555, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sd1, -16'sd32768, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sd32767, 16'sd32767, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, -16'sd32768, 16'sd32767, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, 16'sd32767, -16'sd32768, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, -16'sd1, -16'sd1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, 16'sd0, 16'sd0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, -16'sd32768, -16'sd32768, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, 16'sd12345, -16'sd12345, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, 16'sd32767, 16'sd0, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b0, -16'sd32768, 16'sd1, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sd32767, -16'sd32768, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'sh5555, 16'sh5555, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, 16'shAAAA, 16'shAAAA, 1'b0, '0});
		dir_rows.push_back(stim_row_t'{1'b1, -16'sd32768, -16'sd32768, 1'b0, '0});

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_channel(1'b1);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			if (row.take_left != chan_left) begin
				set_channel(row.take_left);
			end
			send_pair(row.right, row.left, row.typed, row.typed_val);
		end

		fed = 0;
		while (fed < RAND_ITEMS) begin
			quiet <= (fed >= 300 && fed < 450);
			sel = $urandom_range(99);
			if (sel < 4) begin
				set_channel(1'($urandom_range(1)));
			end else if (sel < 14) begin
				// Full-scale burst whose signs follow the coefficients, ending on an output.
				while (phase_mirror != 1) begin
					send_pair(rand_sample(), rand_sample(), 1'b0, '0);
					fed++;
				end
				pos = 1'($urandom_range(1));
				for (lag = HIST_LEN; lag >= 0; lag--) begin
					cidx = (lag < TAPS - 1 - lag) ? lag : TAPS - 1 - lag;
					s = ((dfir_pkg::COEF_TABLE[cidx] >= 0) == pos) ?
						sample_t'(dfir_pkg::SAT_HI) : sample_t'(dfir_pkg::SAT_LO);
					if (chan_left) begin
						send_pair(rand_sample(), s, 1'b0, '0);
					end else begin
						send_pair(s, rand_sample(), 1'b0, '0);
					end
					fed++;
				end
			end else begin
				seg = $urandom_range(1, 40);
				repeat (seg) begin
					send_pair(rand_sample(), rand_sample(), 1'b0, '0);
					fed++;
				end
			end
		end

		in_valid <= 1'b0;
		quiet    <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && pending_out.size() == 0) begin
			$display("PASS decimate_by_four_symmetric_fir_top");
		end else begin
			$display("FAIL decimate_by_four_symmetric_fir_top");
		end
		$finish;
	end

endmodule
